>>> hdl/lspc_pkg.sv
package lspc_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;
  localparam int unsigned WORD_W        = 32;

  typedef enum logic [1:0] {
    MODE_PUSH    = 2'd0,
    MODE_POP     = 2'd1,
    MODE_DISPLAY = 2'd2,
    MODE_CHECK   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2,
    STAT_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_RD,
    S_POP_OUT,
    S_DISP_RD,
    S_DISP_OUT,
    S_PAL_RD,
    S_PAL_CMP
  } state_e;

endpackage

>>> hdl/lspc_ram.sv
module lspc_ram #(
  parameter int unsigned DEPTH = lspc_pkg::DEPTH_DEFAULT,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic                              clk_i,
  input  logic                              we_i,
  input  logic [AW-1:0]                     waddr_i,
  input  logic signed [lspc_pkg::WORD_W-1:0] wdata_i,
  input  logic [AW-1:0]                     raddr_a_i,
  input  logic [AW-1:0]                     raddr_b_i,
  output logic signed [lspc_pkg::WORD_W-1:0] rdata_a_o,
  output logic signed [lspc_pkg::WORD_W-1:0] rdata_b_o
);

  logic signed [lspc_pkg::WORD_W-1:0] mem_q [DEPTH];

  // one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

>>> hdl/lifo_stack_palindrome_check.sv
// push, and check of a stack with fewer than two words: result registered at transfer
// pop: index set, registered store read, then output load once the result register is free
// display: index set, registered store read, output load, per word, top word first
// palindrome check: read, then compare each mirrored pair until mismatch or the ends meet
// input ready only in idle with the result register free; one item at a time
// reset (rst_ni low, asynchronous) empties the stack; stored words are not cleared
module lifo_stack_palindrome_check #(
  parameter int unsigned DEPTH = lspc_pkg::DEPTH_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input channel
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         mode_i,
  input  logic signed [lspc_pkg::WORD_W-1:0] push_value_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [1:0]                         status_o,
  output logic signed [lspc_pkg::WORD_W-1:0] word_out_o,
  output logic                               is_palindrome_o,
  output logic                               last_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // sequencer state and walk pointers
  lspc_pkg::state_e state_q, state_d;
  logic [CW-1:0]    count_q, count_d;   // number of stored words
  logic [AW-1:0]    a_q, a_d;           // pop/display index, low end of the mirror walk
  logic [AW-1:0]    b_q, b_d;           // high end of the mirror walk

  // result register, parts the sequencer from the output handshake
  logic                               out_valid_q, out_valid_d;
  lspc_pkg::status_e                  status_q, status_d;
  logic signed [lspc_pkg::WORD_W-1:0] word_q, word_d;
  logic                               pal_q, pal_d;
  logic                               last_q, last_d;
  logic                               out_load;
  logic                               out_free;

  // word store
  logic                               we;
  logic signed [lspc_pkg::WORD_W-1:0] rdata_a, rdata_b;

  logic              in_xfer;
  lspc_pkg::mode_e   mode;
  logic              full, empty;
  logic [AW-1:0]     span;              // distance between the walk ends
  logic              pair_eq;           // the one shared comparator

  assign mode     = lspc_pkg::mode_e'(mode_i);
  assign full     = (count_q == CW'(DEPTH));
  assign empty    = (count_q == '0);
  assign out_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == lspc_pkg::S_IDLE) && out_free;
  assign in_xfer  = in_valid_i && in_ready_o;
  assign span     = b_q - a_q;
  assign pair_eq  = (rdata_a == rdata_b);

  lspc_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (count_q[AW-1:0]),
    .wdata_i   (push_value_i),
    .raddr_a_i (a_q),
    .raddr_b_i (b_q),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // next state and result loading
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    a_d      = a_q;
    b_d      = b_q;
    we       = 1'b0;
    out_load = 1'b0;
    status_d = lspc_pkg::STAT_OK;
    word_d   = '0;
    pal_d    = 1'b0;
    last_d   = 1'b1;

    unique case (state_q)
      lspc_pkg::S_IDLE: begin
        if (in_xfer) begin
          unique case (mode)
            lspc_pkg::MODE_PUSH: begin
              out_load = 1'b1;
              if (full) begin
                status_d = lspc_pkg::STAT_OVERFLOW;
              end else begin
                we      = 1'b1;
                count_d = count_q + CW'(1);
              end
            end
            lspc_pkg::MODE_POP: begin
              if (empty) begin
                out_load = 1'b1;
                status_d = lspc_pkg::STAT_UNDERFLOW;
              end else begin
                count_d = count_q - CW'(1);
                a_d     = AW'(count_q - CW'(1));
                state_d = lspc_pkg::S_POP_RD;
              end
            end
            lspc_pkg::MODE_DISPLAY: begin
              if (empty) begin
                out_load = 1'b1;
                status_d = lspc_pkg::STAT_EMPTY;
              end else begin
                a_d     = AW'(count_q - CW'(1));
                state_d = lspc_pkg::S_DISP_RD;
              end
            end
            lspc_pkg::MODE_CHECK: begin
              // zero or one word is trivially symmetric
              if (count_q < CW'(2)) begin
                out_load = 1'b1;
                pal_d    = 1'b1;
              end else begin
                a_d     = '0;
                b_d     = AW'(count_q - CW'(1));
                state_d = lspc_pkg::S_PAL_RD;
              end
            end
            default: ;
          endcase
        end
      end
      lspc_pkg::S_POP_RD: begin
        state_d = lspc_pkg::S_POP_OUT;
      end
      lspc_pkg::S_POP_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          word_d   = rdata_a;
          state_d  = lspc_pkg::S_IDLE;
        end
      end
      lspc_pkg::S_DISP_RD: begin
        state_d = lspc_pkg::S_DISP_OUT;
      end
      lspc_pkg::S_DISP_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          word_d   = rdata_a;
          last_d   = (a_q == '0);
          if (a_q == '0) begin
            state_d = lspc_pkg::S_IDLE;
          end else begin
            a_d     = a_q - AW'(1);
            state_d = lspc_pkg::S_DISP_RD;
          end
        end
      end
      lspc_pkg::S_PAL_RD: begin
        state_d = lspc_pkg::S_PAL_CMP;
      end
      lspc_pkg::S_PAL_CMP: begin
        if (!pair_eq) begin
          if (out_free) begin
            out_load = 1'b1;
            state_d  = lspc_pkg::S_IDLE;
          end
        end else if ((AW + 1)'(span) <= (AW + 1)'(2)) begin
          // the ends meet or cross on the next step
          if (out_free) begin
            out_load = 1'b1;
            pal_d    = 1'b1;
            state_d  = lspc_pkg::S_IDLE;
          end
        end else begin
          a_d     = a_q + AW'(1);
          b_d     = b_q - AW'(1);
          state_d = lspc_pkg::S_PAL_RD;
        end
      end
      default: state_d = lspc_pkg::S_IDLE;
    endcase

    out_valid_d = out_load ? 1'b1 : (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lspc_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    if (out_load) begin
      status_q <= status_d;
      word_q   <= word_d;
      pal_q    <= pal_d;
      last_q   <= last_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign word_out_o      = word_q;
  assign is_palindrome_o = pal_q;
  assign last_o          = last_q;

  // fill count stays within the store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("fill count beyond depth");

  // a result is never loaded over one that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("result register overwritten");

  // push into a non-full stack grows it by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && mode == lspc_pkg::MODE_PUSH && !full) |=>
      count_q == $past(count_q) + CW'(1))
    else $error("push did not grow the stack");

  // the mirror walk ends never meet or cross while comparing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lspc_pkg::S_PAL_CMP) |-> (a_q < b_q))
    else $error("mirror walk ends crossed");

endmodule
